// ----- hdl/page_stream_writer_crc32_top_macros.svh -----
// Assertion helpers shared by the block
`ifndef PAGE_STREAM_WRITER_CRC32_TOP_MACROS_SVH
`define PAGE_STREAM_WRITER_CRC32_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define PSWC_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("pswc check failed");

// next-cycle implication, disabled in reset
`define PSWC_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("pswc check failed");

`endif

// ----- hdl/pswc_pkg.sv -----
`default_nettype none

package pswc_pkg;

  localparam int PAGE_REG_W = 13;
  localparam int PAD_REG_W  = 9;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_PAGE_BYTES = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PAD_UNIT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BYTE_LIMIT = 2'd2;

  localparam logic [PAGE_REG_W-1:0] PAGE_BYTES_RST = 13'd256;
  localparam logic [PAD_REG_W-1:0]  PAD_UNIT_RST   = 9'd4;

  localparam logic ACT_DATA     = 1'b0;
  localparam logic ACT_FINALIZE = 1'b1;

  localparam int          DEFAULT_PAD = 4;
  localparam logic [7:0]  PAD_FILL    = 8'hFF;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/pswc_crc8.sv -----
`default_nettype none

module pswc_crc8
  import pswc_pkg::*;
(
  input  wire logic [31:0] crc_in,
  input  wire logic [7:0]  byte_in,
  output logic      [31:0] crc_out
);

  logic [31:0] c;

  always_comb begin
    c = ~crc_in ^ {24'b0, byte_in};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = ~c;
  end

endmodule

`default_nettype wire

// ----- hdl/page_stream_writer_crc32_top.sv -----
`default_nettype none

// Page stream writer with CRC-32. One beat per clock in and out: a slave beat carries a data
// byte (with its chunk length on the first byte of a chunk) or a finalize, and each one gives
// exactly one master beat, passing through an input register and then a result register.
// The byte-wide CRC-32 update and the counter adds are combinational between them, so sustained rate
// is one beat per cycle; master back-pressure stalls the input only once both registers hold.
// Data beats report the write address and a page-complete flag on tlast; the finalize beat
// reports the 0xFF pad count and the final CRC, and everything after it answers invalid.
// Write configuration only while no beat is in flight.

module page_stream_writer_crc32_top
  import pswc_pkg::*;
#(
  parameter int MAX_PAGE_BYTES = 4096,
  parameter int MAX_PAD_UNIT   = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [39:0]           s_tdata,  // chunk_length[31:0], data_byte[39:32]
  input  wire logic [1:0]            s_tuser,  // action[0], chunk_start[1]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [79:0]                m_tdata,  // out_byte[7:0], byte_address[39:8],
                                               // pad_count[47:40], crc_value[79:48]
  output logic [2:0]                 m_tuser,  // status[1:0], byte_valid[2]
  output logic                       m_tlast   // page_done
);

  localparam int PAD_CAP = (MAX_PAD_UNIT > DEFAULT_PAD) ? MAX_PAD_UNIT : DEFAULT_PAD;
  localparam int PW = $clog2(MAX_PAGE_BYTES + 1);
  localparam int GW = $clog2(PAD_CAP + 1);

  logic [PAGE_REG_W-1:0] page_bytes;
  logic [PAD_REG_W-1:0]  pad_unit;
  logic [31:0]           byte_limit;

  logic [31:0]   running_crc, running_crc_next;
  logic [31:0]   streamed_count, streamed_count_next;
  logic [PW-1:0] page_fill, page_fill_next;
  logic [GW-1:0] granule_fill, granule_fill_next;
  logic          chunk_refused, chunk_refused_next;
  logic [31:0]   chunk_left, chunk_left_next;
  logic          ended, ended_next;

  logic        s1_valid;
  logic        s1_action;
  logic        s1_start;
  logic [31:0] s1_len;
  logic [7:0]  s1_byte;
  logic        advance;

  logic        result_valid;
  status_t     out_status, out_status_next;
  logic        out_byte_valid, out_byte_valid_next;
  logic [7:0]  out_byte, out_byte_next;
  logic [31:0] out_addr;
  logic        out_done, out_done_next;
  logic [7:0]  out_pad, out_pad_next;
  logic [31:0] out_crc;

  logic [31:0]   page_w, pad_w, pad_ext;
  logic [PW-1:0] eff_page, page_fill_inc;
  logic [GW-1:0] eff_pad, gran_inc, pad_diff;
  logic          chunk_open, refuse_new, refused;
  logic [31:0]   chunk_n;
  logic [32:0]   reserve_sum;
  logic [31:0]   crc_upd;

  pswc_crc8 u_crc (
    .crc_in  (running_crc),
    .byte_in (s1_byte),
    .crc_out (crc_upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes <= PAGE_BYTES_RST;
      pad_unit   <= PAD_UNIT_RST;
      byte_limit <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PAGE_BYTES: page_bytes <= cfg_data[PAGE_REG_W-1:0];
        CFG_PAD_UNIT:   pad_unit   <= cfg_data[PAD_REG_W-1:0];
        CFG_BYTE_LIMIT: byte_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (page_bytes == '0) begin
      page_w = 32'd1;
    end else if ({{(32-PAGE_REG_W){1'b0}}, page_bytes} > 32'(MAX_PAGE_BYTES)) begin
      page_w = 32'(MAX_PAGE_BYTES);
    end else begin
      page_w = {{(32-PAGE_REG_W){1'b0}}, page_bytes};
    end
    if (pad_unit == '0) begin
      pad_w = 32'(DEFAULT_PAD);
    end else if ({{(32-PAD_REG_W){1'b0}}, pad_unit} > 32'(MAX_PAD_UNIT)) begin
      pad_w = 32'(MAX_PAD_UNIT);
    end else begin
      pad_w = {{(32-PAD_REG_W){1'b0}}, pad_unit};
    end
  end

  assign eff_page = page_w[PW-1:0];
  assign eff_pad  = pad_w[GW-1:0];

  assign advance  = s1_valid && (!result_valid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_action <= s_tuser[0];
      s1_start  <= s_tuser[1];
      s1_len    <= s_tdata[31:0];
      s1_byte   <= s_tdata[39:32];
    end
  end

  always_comb begin
    chunk_open    = s1_start || (chunk_left == '0);
    chunk_n       = s1_start ? s1_len : 32'd1;
    if (chunk_n == '0) begin
      chunk_n = 32'd1;
    end
    reserve_sum   = {1'b0, streamed_count} + {1'b0, chunk_n};
    refuse_new    = reserve_sum > {1'b0, byte_limit};
    refused       = chunk_open ? refuse_new : chunk_refused;
    page_fill_inc = page_fill + PW'(1);
    gran_inc      = granule_fill + GW'(1);
    pad_diff      = eff_pad - granule_fill;
    pad_ext       = 32'(pad_diff);

    running_crc_next    = running_crc;
    streamed_count_next = streamed_count;
    page_fill_next      = page_fill;
    granule_fill_next   = granule_fill;
    chunk_refused_next  = chunk_refused;
    chunk_left_next     = chunk_left;
    ended_next          = ended;
    out_status_next     = ST_OK;
    out_byte_valid_next = 1'b0;
    out_byte_next       = '0;
    out_done_next       = 1'b0;
    out_pad_next        = '0;

    if (ended) begin
      out_status_next = ST_INVALID;
    end else if (s1_action == ACT_FINALIZE) begin
      ended_next = 1'b1;
      if (page_fill != '0) begin
        out_done_next = 1'b1;
        if (granule_fill != '0 && granule_fill < eff_pad) begin
          out_pad_next = pad_ext[7:0];
        end
        page_fill_next    = '0;
        granule_fill_next = '0;
      end
    end else begin
      chunk_refused_next = refused;
      chunk_left_next    = (chunk_open ? chunk_n : chunk_left) - 32'd1;
      if (refused) begin
        out_status_next = ST_OVERFLOW;
      end else begin
        out_byte_valid_next = 1'b1;
        out_byte_next       = s1_byte;
        running_crc_next    = crc_upd;
        streamed_count_next = streamed_count + 32'd1;
        page_fill_next      = page_fill_inc;
        granule_fill_next   = (gran_inc >= eff_pad) ? '0 : gran_inc;
        if (page_fill_inc >= eff_page) begin
          out_done_next     = 1'b1;
          page_fill_next    = '0;
          granule_fill_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc    <= '0;
      streamed_count <= '0;
      page_fill      <= '0;
      granule_fill   <= '0;
      chunk_refused  <= 1'b0;
      chunk_left     <= '0;
      ended          <= 1'b0;
    end else if (advance) begin
      running_crc    <= running_crc_next;
      streamed_count <= streamed_count_next;
      page_fill      <= page_fill_next;
      granule_fill   <= granule_fill_next;
      chunk_refused  <= chunk_refused_next;
      chunk_left     <= chunk_left_next;
      ended          <= ended_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (m_tready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status     <= out_status_next;
      out_byte_valid <= out_byte_valid_next;
      out_byte       <= out_byte_next;
      out_addr       <= streamed_count;
      out_done       <= out_done_next;
      out_pad        <= out_pad_next;
      out_crc        <= running_crc_next;
    end
  end

  assign m_tvalid = result_valid;
  assign m_tdata  = {out_crc, out_pad, out_addr, out_byte};
  assign m_tuser  = {out_byte_valid, out_status};
  assign m_tlast  = out_done;

`include "page_stream_writer_crc32_top_macros.svh"

  `PSWC_ASSERT_NOW(a_bad_status_quiet, result_valid && out_status != ST_OK, !out_byte_valid && !out_done && out_pad == '0 && out_byte == '0)
  `PSWC_ASSERT_NOW(a_pad_closes_page, result_valid && out_pad != '0, out_done && out_status == ST_OK)
  `PSWC_ASSERT_NEXT(a_after_end_invalid, advance && ended, result_valid && out_status == ST_INVALID)

endmodule

`default_nettype wire

// ----- tb/sv/page_stream_writer_crc32_top_test.sv -----
`default_nettype none

module page_stream_writer_crc32_top_test;
  import pswc_pkg::*;

  localparam int PAGE_CAP     = 4096;
  localparam int PAD_CAP      = 256;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_BEATS = 1100;
  localparam string PASS_MSG  = "[page_stream_writer_crc32_top] OK";

  typedef struct packed {
    status_t     status;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic [31:0] byte_address;
    logic        page_done;
    logic [7:0]  pad_count;
    logic [31:0] crc_value;
  } page_write_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  act;
    logic                  first;
    logic [31:0]           len;
    logic [7:0]            data;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  want_refusal;
  } row_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  cfg_we   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [39:0]           s_tdata  = '0;  // chunk_length[31:0], data_byte[39:32]
  logic [1:0]            s_tuser  = '0;  // action[0], chunk_start[1]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [79:0]           m_tdata;        // out_byte[7:0], byte_address[39:8],
                                         // pad_count[47:40], crc_value[79:48]
  logic [2:0]            m_tuser;        // status[1:0], byte_valid[2]
  logic                  m_tlast;

  page_stream_writer_crc32_top #(
    .MAX_PAGE_BYTES(PAGE_CAP),
    .MAX_PAD_UNIT  (PAD_CAP)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [12:0] page_len_reg;
  logic [8:0]  pad_unit_reg;
  logic [31:0] limit_reg;
  logic [31:0] image_crc;
  logic [31:0] sent_total;
  logic [31:0] chunk_due;
  int          page_used;
  int          granule_used;
  bit          chunk_blocked;
  bit          body_closed;

  page_write_t page_writes_due[$];
  row_t        directed[$];

  int errors        = 0;
  int beats_in      = 0;
  int results_seen  = 0;
  int refusals      = 0;
  int pages_closed  = 0;
  int reg_writes    = 0;
  int burst_left    = 0;
  int ready_phase   = 0;
  int ready_mode    = 0;

  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return ~c;
  endfunction

  function automatic int eff_page_len();
    if (page_len_reg == 0) return 1;
    if (page_len_reg > PAGE_CAP) return PAGE_CAP;
    return page_len_reg;
  endfunction

  function automatic int pad_size();
    if (pad_unit_reg == 0) return DEFAULT_PAD;
    if (pad_unit_reg > PAD_CAP) return PAD_CAP;
    return pad_unit_reg;
  endfunction

  function automatic page_write_t next_page_write(logic act, logic first,
                                                  logic [31:0] len, logic [7:0] data);
    page_write_t w;
    logic [31:0] n;
    int          g;
    w = '0;
    w.status = ST_OK;
    w.byte_address = sent_total;
    g = pad_size();
    if (body_closed) begin
      w.status = ST_INVALID;
    end else if (act == ACT_FINALIZE) begin
      body_closed = 1'b1;
      if (page_used != 0) begin
        w.page_done = 1'b1;
        if (granule_used != 0 && granule_used < g) w.pad_count = 8'(g - granule_used);
        page_used = 0;
        granule_used = 0;
      end
    end else begin
      if (first || chunk_due == 0) begin
        n = first ? len : 32'd1;
        if (n == 0) n = 32'd1;
        chunk_blocked = ({1'b0, sent_total} + {1'b0, n}) > {1'b0, limit_reg};
        chunk_due = n;
      end
      chunk_due = chunk_due - 32'd1;
      if (chunk_blocked) begin
        w.status = ST_OVERFLOW;
      end else begin
        w.byte_valid = 1'b1;
        w.out_byte = data;
        image_crc = crc32_byte(image_crc, data);
        sent_total = sent_total + 32'd1;
        page_used++;
        granule_used = (granule_used + 1 >= g) ? 0 : granule_used + 1;
        if (page_used >= eff_page_len()) begin
          w.page_done = 1'b1;
          page_used = 0;
          granule_used = 0;
        end
      end
    end
    w.crc_value = image_crc;
    return w;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= 40) $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic send_beat(logic act, logic first, logic [31:0] len, logic [7:0] data,
                           logic want_refusal);
    page_write_t w;
    int          gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {data, len};
    s_tuser  <= {first, act};
    do @(posedge clk); while (!s_tready);
    w = next_page_write(act, first, len, data);
    if (want_refusal) begin
      w = '0;
      w.status = ST_OVERFLOW;
    end
    page_writes_due.push_back(w);
    beats_in++;
  endtask

  // drop valid and let every pending beat come out
  task automatic settle();
    s_tvalid <= 1'b0;
    while (page_writes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_PAGE_BYTES: page_len_reg = val[PAGE_REG_W-1:0];
      CFG_PAD_UNIT:   pad_unit_reg = val[PAD_REG_W-1:0];
      CFG_BYTE_LIMIT: limit_reg    = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic add_beat(logic act, logic first, logic [31:0] len, logic [7:0] data,
                          logic want_refusal);
    row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.act = act;
    r.first = first;
    r.len = len;
    r.data = data;
    r.want_refusal = want_refusal;
    directed.push_back(r);
  endtask

  task automatic add_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    directed.push_back(r);
  endtask

  always @(posedge clk) begin
    if (ready_phase == 0) begin
      ready_mode  <= $urandom_range(0, 3);
      ready_phase <= $urandom_range(8, 80);
    end else begin
      ready_phase <= ready_phase - 1;
    end
    case (ready_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= $urandom_range(0, 1);
      2:       m_tready <= ($urandom_range(0, 5) == 0);
      default: m_tready <= ready_phase[1];
    endcase
  end

  always @(posedge clk) begin : take_result
    page_write_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (page_writes_due.size() == 0) begin
        report("result beat with no write pending");
      end else begin
        want = page_writes_due.pop_front();
        if (m_tuser[1:0] !== want.status)
          report($sformatf("status got %0d want %0d", m_tuser[1:0], want.status));
        if (m_tuser[2] !== want.byte_valid)
          report($sformatf("byte_valid got %0b want %0b", m_tuser[2], want.byte_valid));
        if (m_tdata[7:0] !== want.out_byte)
          report($sformatf("out_byte got %02h want %02h", m_tdata[7:0], want.out_byte));
        if (m_tdata[39:8] !== want.byte_address)
          report($sformatf("byte_address got %0d want %0d", m_tdata[39:8],
                           want.byte_address));
        if (m_tlast !== want.page_done)
          report($sformatf("page_done got %0b want %0b", m_tlast, want.page_done));
        if (m_tdata[47:40] !== want.pad_count)
          report($sformatf("pad_count got %0d want %0d", m_tdata[47:40], want.pad_count));
        if (m_tdata[79:48] !== want.crc_value)
          report($sformatf("crc got %08h want %08h", m_tdata[79:48], want.crc_value));
        results_seen++;
        if (want.status == ST_OVERFLOW) refusals++;
        if (want.page_done) pages_closed++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("[page_stream_writer_crc32_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    int          kind;
    int          clen;
    int          body;
    int          fill;
    int          random_goal;
    int          phase_goal;
    logic        has_start;
    logic [31:0] first_len;
    logic [31:0] pick;

    page_len_reg   = PAGE_BYTES_RST;
    pad_unit_reg   = PAD_UNIT_RST;
    limit_reg      = '0;
    image_crc      = '0;
    sent_total     = '0;
    chunk_due      = '0;
    page_used      = 0;
    granule_used   = 0;
    chunk_blocked  = 1'b0;
    body_closed    = 1'b0;

    // limit is zero out of reset: everything is refused
    add_beat(ACT_DATA, 1'b1, 32'd1, 8'h00, 1'b1);
    add_beat(ACT_DATA, 1'b0, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    add_beat(ACT_DATA, 1'b1, 32'd0, 8'h5A, 1'b1);
    add_reg(CFG_BYTE_LIMIT, 32'hFFFF_FFFF);
    add_reg(CFG_PAGE_BYTES, 32'd0);
    add_reg(CFG_PAD_UNIT, 32'd0);
    add_beat(ACT_DATA, 1'b1, 32'd3, 8'h00, 1'b0);
    add_beat(ACT_DATA, 1'b0, 32'd0, 8'hFF, 1'b0);
    add_beat(ACT_DATA, 1'b0, 32'd0, 8'hA5, 1'b0);
    add_reg(CFG_PAGE_BYTES, 32'd8191);
    add_reg(CFG_PAD_UNIT, 32'd511);
    add_beat(ACT_DATA, 1'b1, 32'hFFFF_FFFF, 8'h11, 1'b0);
    add_beat(ACT_DATA, 1'b0, 32'd0, 8'h22, 1'b0);
    add_beat(ACT_DATA, 1'b1, 32'd4, 8'h33, 1'b0);
    add_beat(ACT_DATA, 1'b0, 32'd0, 8'h44, 1'b0);
    add_reg(CFG_BYTE_LIMIT, 32'd5);
    add_beat(ACT_DATA, 1'b0, 32'd0, 8'h55, 1'b0);
    add_beat(ACT_DATA, 1'b0, 32'd0, 8'h66, 1'b0);
    add_beat(ACT_DATA, 1'b1, 32'd1, 8'h77, 1'b0);
    add_reg(CFG_BYTE_LIMIT, 32'h0001_0000);
    add_reg(CFG_PAGE_BYTES, 32'd4);
    add_reg(CFG_PAD_UNIT, 32'd2);
    add_beat(ACT_DATA, 1'b1, 32'd6, 8'h80, 1'b0);
    for (int i = 1; i < 6; i++) add_beat(ACT_DATA, 1'b0, 32'd0, 8'h80 + 8'(i), 1'b0);
    add_beat(ACT_DATA, 1'b1, 32'd5, 8'hC3, 1'b0);
    add_beat(ACT_DATA, 1'b1, 32'd1, 8'h3C, 1'b0);
    add_beat(ACT_DATA, 1'b0, 32'h5555_AAAA, 8'h01, 1'b0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG) write_reg(directed[i].reg_idx, directed[i].reg_val);
      else send_beat(directed[i].act, directed[i].first, directed[i].len, directed[i].data,
                     directed[i].want_refusal);
    end

    random_goal = beats_in + RANDOM_BEATS;
    while (beats_in < random_goal) begin
      case ($urandom_range(0, 5))
        0:       pick = 32'd0;
        1:       pick = $urandom_range(1, 8);
        2:       pick = $urandom_range(0, 511);
        3:       pick = PAD_CAP;
        4:       pick = 32'd511;
        default: pick = $urandom_range(1, 4);
      endcase
      write_reg(CFG_PAD_UNIT, pick);
      case ($urandom_range(0, 7))
        0:       pick = 32'd0;
        1, 2:    pick = $urandom_range(1, 16);
        3, 4:    pick = pad_size() * $urandom_range(1, 6);
        5:       pick = $urandom_range(0, 8191);
        6:       pick = PAGE_CAP;
        default: pick = $urandom_range(17, 64);
      endcase
      write_reg(CFG_PAGE_BYTES, pick);
      case ($urandom_range(0, 5))
        0, 1, 2: pick = sent_total + $urandom_range(20, 400);
        3:       pick = 32'hFFFF_FFFF;
        4:       pick = $urandom;
        default: pick = $urandom_range(0, 1) ? 32'd0 : sent_total;
      endcase
      write_reg(CFG_BYTE_LIMIT, pick);

      phase_goal = beats_in + $urandom_range(60, 200);
      while (beats_in < phase_goal && beats_in < random_goal) begin
        kind = $urandom_range(0, 19);
        clen = $urandom_range(1, 12);
        has_start = 1'b1;
        first_len = clen;
        case (kind)
          14: begin
            first_len = 32'd0;
            body = $urandom_range(0, 2);
          end
          15: begin
            first_len = $urandom;
            body = $urandom_range(0, 4);
          end
          16: body = $urandom_range(0, clen - 1);
          17: begin
            has_start = 1'b0;
            body = $urandom_range(1, 3);
          end
          18, 19: body = clen - 1 + $urandom_range(1, 3);
          default: body = clen - 1;
        endcase
        if (has_start) send_beat(ACT_DATA, 1'b1, first_len, $urandom_range(0, 255), 1'b0);
        repeat (body) send_beat(ACT_DATA, 1'b0, $urandom, $urandom_range(0, 255), 1'b0);
      end
    end

    write_reg(CFG_BYTE_LIMIT, 32'hFFFF_FFFF);
    case ($urandom_range(0, 3))
      0:       pick = 32'd1;
      1:       pick = 32'd0;
      2:       pick = $urandom_range(0, 511);
      default: pick = pad_unit_reg;
    endcase
    write_reg(CFG_PAD_UNIT, pick);
    if ($urandom_range(0, 2) == 0 && page_used != 0) begin
      fill = eff_page_len() - page_used;
      send_beat(ACT_DATA, 1'b1, fill, $urandom_range(0, 255), 1'b0);
      repeat (fill - 1) send_beat(ACT_DATA, 1'b0, $urandom, $urandom_range(0, 255), 1'b0);
    end
    send_beat(ACT_FINALIZE, $urandom_range(0, 1), $urandom, $urandom_range(0, 255), 1'b0);
    repeat (6) send_beat($urandom_range(0, 1), $urandom_range(0, 1), $urandom,
                         $urandom_range(0, 255), 1'b0);

    s_tvalid <= 1'b0;
    while (page_writes_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (page_writes_due.size() != 0) report("writes still pending at end of run");

    $display("covered %0d input beats and %0d results: %0d refused, %0d page closes",
             beats_in, results_seen, refusals, pages_closed);
    $display("%0d register writes, %0d bytes streamed, final crc %08h",
             reg_writes, sent_total, image_crc);
    if (errors == 0) $display(PASS_MSG);
    else $display("[page_stream_writer_crc32_top] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
